/* rtl/assert_macros.svh */
// shared assertion macros for the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/etrns_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrns_pkg
// Types and constants shared by the timestamp ring and its search logic.
// ----------------------------------------------------------------------------
package etrns_pkg;

	// timestamp width in bits
	localparam int TIME_W = 64;
	// default number of ring slots
	localparam int RING_DEPTH_DEF = 8;

	// operation selector on the input stream
	typedef enum logic [1:0] {
		FUNC_RECORD = 2'd0,
		FUNC_BEFORE = 2'd1,
		FUNC_AFTER  = 2'd2,
		FUNC_IGNORE = 2'd3
	} func_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// control from sequencer to the search unit
	typedef struct packed {
		logic start;       // load query, clear best
		logic dir_before;  // newest-before search when set
		logic step;        // compare the entry on the read port
	} srch_ctl_t;

endpackage

/* rtl/event_timestamp_ring_nearest_search_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_timestamp_ring_nearest_search_top
// Ring of captured event timestamps with newest-before / oldest-after search.
// ----------------------------------------------------------------------------
// A record beat writes the head slot when enabled. A query walks the ring
// through one read port and one shared comparator, one slot per cycle in
// ST_SCAN; ST_DRAIN compares the last registered read, and in ST_DONE the
// result is registered once the output register is free. The input is
// ready again at that same edge. A query while disabled skips the scan
// and goes straight to ST_DONE, giving found 0. A finished result waits in
// the output register while the next beat is taken; only a further query
// result stalls behind it. Zero timestamps count as empty slots.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module event_timestamp_ring_nearest_search_top
	import etrns_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*TIME_W-1:0] s_tdata,   // time_us [63:0], range_us [127:64]
	input  logic [1:0]          s_tuser,   // func [1:0]
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TIME_W-1:0]   m_tdata,   // anchor_time [63:0]
	output logic                m_tuser,   // found [0]
	// enable register write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

	state_t            state_q;
	state_t            state_d;
	logic              enable_q;
	logic [AW-1:0]     scan_idx_q;
	logic              step_s1;
	logic              out_vld_q;
	logic              out_found_q;
	logic [TIME_W-1:0] out_anchor_q;

	logic              in_acc;
	func_t             func;
	logic              is_query;
	logic              wr_en;
	logic              load_out;
	srch_ctl_t         ctl;
	logic [TIME_W-1:0] rd_data;
	logic              hit;
	logic [TIME_W-1:0] best;

	assign func     = func_t'(s_tuser);
	assign in_acc   = s_tvalid && s_tready;
	assign is_query = (func == FUNC_BEFORE) || (func == FUNC_AFTER);

	// enable register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_query) begin
					state_d = enable_q ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_idx_q == LAST_SLOT) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_vld_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		wr_en          = in_acc && (func == FUNC_RECORD) && enable_q;
		ctl.start      = in_acc && is_query;
		ctl.dir_before = (func == FUNC_BEFORE);
		ctl.step       = step_s1;
		load_out       = (state_q == ST_DONE) && (!out_vld_q || m_tready);
	end

	// state, scan index and compare strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			step_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			step_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				scan_idx_q <= (scan_idx_q == LAST_SLOT) ? '0 : scan_idx_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_found_q  <= hit;
			out_anchor_q <= best;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = out_anchor_q;

	etrns_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (s_tdata[TIME_W-1:0]),
		.rd_addr (scan_idx_q),
		.rd_data (rd_data)
	);

	etrns_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.q_time  (s_tdata[TIME_W-1:0]),
		.q_range (s_tdata[2*TIME_W-1:TIME_W]),
		.entry   (rd_data),
		.hit     (hit),
		.best    (best)
	);

	// checks
	`ASSERT_PROP(a_out_from_done, clk, arst_n, $rose(m_tvalid) |-> $past(state_q) == ST_DONE, "result beat not from done state")
	`ASSERT_PROP(a_miss_zero, clk, arst_n, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "miss with nonzero anchor")
	`ASSERT_PROP(a_idle_idx, clk, arst_n, (state_q == ST_IDLE) |-> (scan_idx_q == '0), "scan index not rewound")
	`ASSERT_PROP(a_drain_done, clk, arst_n, (state_q == ST_DRAIN) |=> (state_q == ST_DONE), "drain not followed by done")

endmodule

/* rtl/etrns_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrns_ring
// Timestamp ring storage: one write port at the head slot, one registered
// read port. Slots never written since reset read as zero.
// ----------------------------------------------------------------------------
module etrns_ring
	import etrns_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int AW = $clog2(RING_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [TIME_W-1:0] wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [TIME_W-1:0] rd_data
);

	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

	logic [TIME_W-1:0]     mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] vld_q;
	logic [AW-1:0]         head_q;
	logic [TIME_W-1:0]     rd_mem_q;
	logic                  rd_vld_q;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head_q] <= wr_data;
		end
		rd_mem_q <= mem[rd_addr];
	end

	// head pointer, slot valid bits and registered read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (wr_en) begin
				vld_q[head_q] <= 1'b1;
				head_q        <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
			end
		end
	end

	// unwritten slots read as empty
	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

/* rtl/etrns_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrns_search
// Shared compare unit: checks one ring entry per step against the held
// query and keeps the best match found so far.
// ----------------------------------------------------------------------------
module etrns_search
	import etrns_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  srch_ctl_t         ctl,
	input  logic [TIME_W-1:0] q_time,
	input  logic [TIME_W-1:0] q_range,
	input  logic [TIME_W-1:0] entry,
	output logic              hit,
	output logic [TIME_W-1:0] best
);

	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] range_q;
	logic              before_q;
	logic              hit_q;
	logic [TIME_W-1:0] best_q;

	logic [TIME_W:0]   diff;
	logic              order_ok;
	logic              dist_ok;
	logic              better;
	logic              take;

	// distance in the search direction, borrow gives the ordering
	always_comb begin
		if (before_q) begin
			diff = {1'b0, time_q} - {1'b0, entry};
		end else begin
			diff = {1'b0, entry} - {1'b0, time_q};
		end
		order_ok = !diff[TIME_W] && (before_q || (diff[TIME_W-1:0] != '0));
		dist_ok  = diff[TIME_W-1:0] <= range_q;
		better   = !hit_q || (before_q ? (entry > best_q) : (entry < best_q));
		take     = ctl.step && (entry != '0) && order_ok && dist_ok && better;
	end

	// query hold and running best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			best_q   <= '0;
			before_q <= 1'b0;
		end else if (ctl.start) begin
			hit_q    <= 1'b0;
			best_q   <= '0;
			before_q <= ctl.dir_before;
		end else if (take) begin
			hit_q  <= 1'b1;
			best_q <= entry;
		end
	end

	// query operands, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			time_q  <= q_time;
			range_q <= q_range;
		end
	end

	assign hit  = hit_q;
	assign best = best_q;

endmodule

/* sim/event_timestamp_ring_nearest_search_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_timestamp_ring_nearest_search_top_test
// Self-checking bench for the timestamp ring with nearest-anchor search.
// ----------------------------------------------------------------------------
// Record and query beats go in on the input stream and each query result is
// compared with a shadow copy of the ring kept in the bench. The run starts
// with hand-picked cases: the disabled block, the empty ring, the extremes of
// time and range, equal and zero entries, the ignored selector and
// re-enabling. After that come phases of random traffic around a moving
// base time, with the enable bit changed between phases. Both sides idle at
// random, and some phases run without idling.
// ----------------------------------------------------------------------------
module event_timestamp_ring_nearest_search_top_test;
	import etrns_pkg::*;

	localparam int DEPTH     = RING_DEPTH_DEF;
	localparam int HOLD_OFF  = DEPTH + 8;
	localparam int PHASES    = 12;
	localparam int PER_PHASE = 148;
	localparam logic [TIME_W-1:0] T_MAX = '1;

	typedef struct packed {
		logic              found;
		logic [TIME_W-1:0] anchor;
	} lookup_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [2*TIME_W-1:0] s_tdata;   // time_us [63:0], range_us [127:64]
	logic [1:0]          s_tuser;   // func [1:0]
	logic                m_tvalid;
	logic                m_tready;
	logic [TIME_W-1:0]   m_tdata;   // anchor_time [63:0]
	logic                m_tuser;   // found [0]
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_data;

	// shadow of the ring, head slot and enable bit
	logic [TIME_W-1:0] shadow_ring [DEPTH];
	int unsigned       shadow_head;
	logic              shadow_en;

	lookup_t pending_lookups[$];
	int      err_count;
	bit      idle_on;
	bit      stall_on;
	int      stall_left;

	event_timestamp_ring_nearest_search_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic void note_error(string what, lookup_t want, lookup_t got);
		err_count++;
		if (err_count <= 10) begin
			$display("%0t: %s: expected found=%0d anchor=%h, got found=%0d anchor=%h",
				$realtime, what, want.found, want.anchor, got.found, got.anchor);
		end
	endfunction

	// nearest anchor search over the shadow ring
	function automatic lookup_t nearest_anchor(logic want_before, logic [TIME_W-1:0] t,
			logic [TIME_W-1:0] r);
		lookup_t res;
		logic [TIME_W-1:0] a;
		res = '0;
		if (!shadow_en)
			return res;
		for (int k = 0; k < DEPTH; k++) begin
			a = shadow_ring[k];
			if (a == '0)
				continue;
			if (want_before) begin
				if (a <= t && (t - a) <= r && a > res.anchor) begin
					res.anchor = a;
					res.found  = 1'b1;
				end
			end else if (a > t && (a - t) <= r && (!res.found || a < res.anchor)) begin
				res.anchor = a;
				res.found  = 1'b1;
			end
		end
		return res;
	endfunction

	// update the shadow for one accepted beat
	function automatic void apply_beat(func_t f, logic [TIME_W-1:0] t, logic [TIME_W-1:0] r);
		case (f)
			FUNC_RECORD: begin
				if (shadow_en) begin
					shadow_ring[shadow_head] = t;
					shadow_head = (shadow_head + 1) % DEPTH;
				end
			end
			FUNC_BEFORE: pending_lookups.push_back(nearest_anchor(1'b1, t, r));
			FUNC_AFTER:  pending_lookups.push_back(nearest_anchor(1'b0, t, r));
			default: ;
		endcase
	endfunction

	// one beat on the input stream, with a random gap before it when idling is on
	task automatic send_item(func_t f, logic [TIME_W-1:0] t, logic [TIME_W-1:0] r);
		int gap;
		gap = idle_on ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {r, t};
		do @(posedge clk); while (!s_tready);
		apply_beat(f, t, r);
	endtask

	// stop the stream and let the block settle
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic write_enable(logic v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_en = v;
	endtask

	// result side: random stalls and comparison
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_lookups.size() == 0) begin
				note_error("result with no query pending", '0, {m_tuser, m_tdata});
			end else if (pending_lookups[0] !== {m_tuser, m_tdata}) begin
				note_error("result mismatch", pending_lookups[0], {m_tuser, m_tdata});
				void'(pending_lookups.pop_front());
			end else begin
				void'(pending_lookups.pop_front());
			end
			stall_left = stall_on ? $urandom_range(0, 18) : 0;
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// reset value of enable is off: records dropped, queries fail
	task automatic test_disabled_block;
		send_item(FUNC_RECORD, 64'd100, '0);
		send_item(FUNC_BEFORE, 64'd200, T_MAX);
		send_item(FUNC_AFTER, 64'd0, T_MAX);
		send_item(FUNC_IGNORE, 64'd50, T_MAX);
	endtask

	task automatic test_empty_ring;
		send_item(FUNC_BEFORE, T_MAX, T_MAX);
		send_item(FUNC_AFTER, 64'd0, T_MAX);
	endtask

	// extremes, equal entries, a recorded zero and the unused selector
	task automatic test_directed_search;
		send_item(FUNC_RECORD, 64'd1, '0);
		send_item(FUNC_RECORD, T_MAX, '0);
		send_item(FUNC_RECORD, 64'd1000, '0);
		send_item(FUNC_RECORD, 64'd1000, T_MAX);
		send_item(FUNC_RECORD, 64'd0, '0);
		send_item(FUNC_RECORD, 64'd5000, '0);
		send_item(FUNC_BEFORE, T_MAX, T_MAX);
		send_item(FUNC_BEFORE, 64'd999, T_MAX);
		send_item(FUNC_BEFORE, 64'd1000, 64'd0);
		send_item(FUNC_BEFORE, 64'd1001, 64'd0);
		send_item(FUNC_BEFORE, 64'd0, T_MAX);
		send_item(FUNC_AFTER, 64'd0, 64'd0);
		send_item(FUNC_AFTER, 64'd0, 64'd1);
		send_item(FUNC_AFTER, 64'd1000, T_MAX);
		send_item(FUNC_AFTER, T_MAX - 1, 64'd1);
		send_item(FUNC_IGNORE, 64'd1000, T_MAX);
	endtask

	// entries and head survive a disable / enable cycle
	task automatic test_re_enable;
		write_enable(1'b0);
		send_item(FUNC_RECORD, 64'd7, '0);
		send_item(FUNC_BEFORE, T_MAX, T_MAX);
		write_enable(1'b1);
		send_item(FUNC_BEFORE, T_MAX, T_MAX);
	endtask

	function automatic logic [TIME_W-1:0] pick_time(logic [TIME_W-1:0] base);
		case ($urandom_range(0, 9))
			0:       return {$urandom, $urandom};
			1:       return '0;
			2:       return T_MAX;
			default: return base + TIME_W'($urandom_range(0, 3000)) - 64'd1500;
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_range();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return T_MAX;
			2:       return {$urandom, $urandom};
			3:       return {$urandom, $urandom} >> $urandom_range(0, 63);
			default: return TIME_W'($urandom_range(0, 2000));
		endcase
	endfunction

	// clustered records and queries around a base time per phase
	task automatic test_random_traffic;
		logic [TIME_W-1:0] base;
		int                sent;
		int                pick;
		for (int phase = 0; phase < PHASES; phase++) begin
			idle_on  = (phase % 3) != 2;
			stall_on = (phase % 4) != 3;
			write_enable((phase % 5) != 3);
			case ($urandom_range(0, 2))
				0:       base = TIME_W'($urandom_range(1, 4000));
				1:       base = {$urandom, $urandom};
				default: base = T_MAX - TIME_W'($urandom_range(0, 4000));
			endcase
			sent = 0;
			while (sent < PER_PHASE) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					send_item(FUNC_RECORD, pick_time(base), {$urandom, $urandom});
					sent++;
				end else if (pick < 68) begin
					send_item(FUNC_BEFORE, pick_time(base), pick_range());
					sent++;
				end else if (pick < 96) begin
					send_item(FUNC_AFTER, pick_time(base), pick_range());
					sent++;
				end else begin
					send_item(FUNC_IGNORE, {$urandom, $urandom}, {$urandom, $urandom});
				end
			end
		end
	endtask

	// main sequence
	initial begin
		for (int k = 0; k < DEPTH; k++)
			shadow_ring[k] = '0;
		shadow_head = 0;
		shadow_en   = 1'b0;
		err_count   = 0;
		stall_left  = 0;
		idle_on     = 1'b1;
		stall_on    = 1'b1;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FUNC_RECORD;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_block();
		write_enable(1'b1);
		test_empty_ring();
		test_directed_search();
		test_re_enable();
		test_random_traffic();
		drain();

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/etrns_pkg.sv
rtl/etrns_ring.sv
rtl/etrns_search.sv
rtl/event_timestamp_ring_nearest_search_top.sv
sim/event_timestamp_ring_nearest_search_top_test.sv
